@@ hw/rtl/kuf_pkg.sv @@
// Shared types and constants for the union-find edge filter.
// Used by the controller, the datapath, the top level and the checker.
package kuf_pkg;

  localparam int VID_W    = 10;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 32;
  localparam int REJ_W    = 20;
  localparam int COMP_W   = 11;
  localparam int CFG_W    = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef struct packed {
    logic                start_req;
    logic [VID_W-1:0]    vertex_a;
    logic [VID_W-1:0]    vertex_b;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } kuf_in_t;

  typedef struct packed {
    logic             accepted;
    logic [SUM_W-1:0] total_weight;
    logic [REJ_W-1:0] rejected_count;
    logic             spanning;
    logic [VID_W-1:0] root_vertex;
    logic             out_of_range;
    logic             last_out;
  } kuf_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_RD,
    ST_FIND,
    ST_COMPRESS,
    ST_LINK,
    ST_RANK_UP,
    ST_FINISH
  } kuf_state_t;

  typedef enum logic {
    ADDR_END,
    ADDR_PAR
  } kuf_addr_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_COMPRESS,
    WR_LINK,
    WR_RANK_UP
  } kuf_wr_src_t;

  typedef struct packed {
    logic          load;
    logic          rd_en;
    kuf_addr_sel_t addr_sel;
    kuf_wr_src_t   wr_src;
    logic          cap_root;
    logic          reject;
    logic          merge;
    logic          emit;
    logic          sel;
  } kuf_cmd_t;

  typedef struct packed {
    logic clr_more;
    logic bad;
    logic hit;
    logic end_is_root;
    logic next_is_root;
    logic same_root;
    logic rank_eq;
  } kuf_stat_t;

endpackage

@@ hw/rtl/kuf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/kuf_ctrl.sv @@
// Sequencer for the union-find edge filter: clear sweep, two find walks
// with path compression, union and result strobe. Depends on kuf_pkg.
module kuf_ctrl
  import kuf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      start_req,
  input  kuf_stat_t stat,
  output kuf_cmd_t  cmd,
  output logic      busy
);

  kuf_state_t state_r, state_nxt;
  logic       sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      ST_INIT: begin
        if (!stat.clr_more) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          sel_nxt   = 1'b0;
          state_nxt = start_req ? ST_CLEAR : ST_FIND_RD;
        end
      end
      ST_CLEAR: begin
        if (!stat.clr_more) state_nxt = ST_FIND_RD;
      end
      ST_FIND_RD: begin
        if (!sel_r && stat.bad) state_nxt = ST_FINISH;
        else state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (stat.hit) begin
          if (!stat.end_is_root) begin
            state_nxt = ST_COMPRESS;
          end else if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = ST_FIND_RD;
          end else begin
            state_nxt = ST_LINK;
          end
        end
      end
      ST_COMPRESS: begin
        if (stat.next_is_root) begin
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = ST_FIND_RD;
          end else begin
            state_nxt = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        if (!stat.same_root && stat.rank_eq) state_nxt = ST_RANK_UP;
        else state_nxt = ST_FINISH;
      end
      ST_RANK_UP: state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_END;
    cmd.wr_src   = WR_NONE;
    cmd.sel      = sel_r;
    busy         = 1'b1;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        if (stat.clr_more) cmd.wr_src = WR_CLEAR;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_FIND_RD: begin
        if (sel_r || !stat.bad) cmd.rd_en = 1'b1;
      end
      ST_FIND: begin
        cmd.rd_en = 1'b1;
        if (stat.hit) begin
          // root found: restart at the endpoint for the compression walk
          cmd.cap_root = 1'b1;
          cmd.addr_sel = ADDR_END;
        end else begin
          cmd.addr_sel = ADDR_PAR;
        end
      end
      ST_COMPRESS: begin
        cmd.wr_src   = WR_COMPRESS;
        cmd.addr_sel = ADDR_PAR;
        cmd.rd_en    = !stat.next_is_root;
      end
      ST_LINK: begin
        if (stat.same_root) begin
          cmd.reject = 1'b1;
        end else begin
          cmd.wr_src = WR_LINK;
          cmd.merge  = 1'b1;
        end
      end
      ST_RANK_UP: cmd.wr_src = WR_RANK_UP;
      ST_FINISH:  cmd.emit = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/kuf_datapath.sv @@
// Datapath of the union-find edge filter: parent/rank RAM, walk registers,
// counters, config register and the result register. Depends on kuf_pkg, kuf_ram.
module kuf_datapath
  import kuf_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kuf_in_t          in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  kuf_cmd_t         cmd,
  output kuf_stat_t        stat,
  output logic             out_valid,
  output kuf_out_t         out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  // rank field: 8 bits, held at its top value
  localparam int RW = 8;
  localparam int EW = AW + RW;
  localparam int LW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);
  localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} :
                                          WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  // configuration
  logic [CFG_W-1:0] nv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= CFG_RESET;
    else if (cfg_we) nv_r <= cfg_wdata;
  end

  logic [CW-1:0] cfg_ext, lim_full;
  logic          bad_now;
  assign cfg_ext  = CW'(nv_r);
  assign lim_full = (cfg_ext < MAXV) ? cfg_ext : MAXV;
  assign bad_now  = (CW'(in_data.vertex_a) >= lim_full) ||
                    (CW'(in_data.vertex_b) >= lim_full);

  // item registers (payload, no reset)
  logic [AW-1:0]       va_r, vb_r;
  logic [WEIGHT_W-1:0] w_r;
  logic                last_r, bad_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r   <= AW'(in_data.vertex_a);
      vb_r   <= AW'(in_data.vertex_b);
      w_r    <= in_data.weight & WMASK;
      last_r <= in_data.last;
      bad_r  <= bad_now;
    end
  end

  // RAM entry is {rank, parent}
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, q;
  logic [AW-1:0] q_par;
  logic [RW-1:0] q_rank;

  assign q_par  = q[AW-1:0];
  assign q_rank = q[EW-1:AW];

  logic [AW-1:0] cur_r, root_a_r, root_b_r;
  logic [RW-1:0] rank_a_r, rank_b_r;
  logic [LW-1:0] clr_idx_r, limit_r;
  logic [AW-1:0] end_v, root_sel;
  logic          a_gt;

  assign end_v    = cmd.sel ? vb_r : va_r;
  assign root_sel = cmd.sel ? root_b_r : root_a_r;
  assign a_gt     = rank_a_r > rank_b_r;
  assign rd_addr  = (cmd.addr_sel == ADDR_PAR) ? q_par : end_v;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_r;
    wr_data = {q_rank, root_sel};
    unique case (cmd.wr_src)
      WR_NONE: wr_en = 1'b0;
      WR_CLEAR: begin
        wr_addr = clr_idx_r[AW-1:0];
        wr_data = {{RW{1'b0}}, clr_idx_r[AW-1:0]};
      end
      WR_COMPRESS: begin
        wr_addr = cur_r;
        wr_data = {q_rank, root_sel};
      end
      WR_LINK: begin
        if (a_gt) begin
          wr_addr = root_b_r;
          wr_data = {rank_b_r, root_a_r};
        end else begin
          wr_addr = root_a_r;
          wr_data = {rank_a_r, root_b_r};
        end
      end
      WR_RANK_UP: begin
        wr_addr = root_b_r;
        wr_data = {(rank_b_r == {RW{1'b1}}) ? rank_b_r : rank_b_r + RW'(1), root_b_r};
      end
      default: wr_en = 1'b0;
    endcase
  end

  kuf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (q)
  );

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.rd_en) cur_r <= rd_addr;
    if (cmd.cap_root) begin
      if (cmd.sel) begin
        root_b_r <= cur_r;
        rank_b_r <= q_rank;
      end else begin
        root_a_r <= cur_r;
        rank_a_r <= q_rank;
      end
    end
  end

  // clear sweep: reset covers every entry, a start covers the ones in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      limit_r   <= LW'(MAX_VERTICES);
    end else if (cmd.load) begin
      clr_idx_r <= '0;
      limit_r   <= LW'(lim_full);
    end else if (cmd.wr_src == WR_CLEAR) begin
      clr_idx_r <= clr_idx_r + LW'(1);
    end
  end

  // counters
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [REJ_W-1:0]  rej_r, rej_nxt;
  logic [COMP_W-1:0] comps_r, comps_nxt;
  logic [AW-1:0]     recent_r, recent_nxt;
  logic              acc_r, acc_nxt;
  logic [SUM_W:0]    sum_wide;
  logic              had_a, had_b;

  assign had_a    = rank_a_r != '0;
  assign had_b    = rank_b_r != '0;
  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(w_r);

  always_comb begin
    sum_nxt    = sum_r;
    rej_nxt    = rej_r;
    comps_nxt  = comps_r;
    recent_nxt = recent_r;
    acc_nxt    = acc_r;
    if (cmd.load) begin
      acc_nxt = 1'b0;
      if (in_data.start_req) begin
        sum_nxt    = '0;
        rej_nxt    = '0;
        comps_nxt  = '0;
        recent_nxt = '0;
      end
    end
    if (cmd.reject && rej_r != {REJ_W{1'b1}}) begin
      rej_nxt = rej_r + REJ_W'(1);
    end
    if (cmd.merge) begin
      acc_nxt    = 1'b1;
      recent_nxt = a_gt ? root_a_r : root_b_r;
      sum_nxt    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      if (!had_a && !had_b) begin
        comps_nxt = comps_r + COMP_W'(1);
      end else if (had_a && had_b && comps_r != '0) begin
        comps_nxt = comps_r - COMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      rej_r    <= '0;
      comps_r  <= '0;
      recent_r <= '0;
      acc_r    <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      rej_r    <= rej_nxt;
      comps_r  <= comps_nxt;
      recent_r <= recent_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // result register
  kuf_out_t out_r;
  logic     out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.accepted       <= acc_r;
      out_r.total_weight   <= sum_r;
      out_r.rejected_count <= rej_r;
      out_r.spanning       <= comps_r == COMP_W'(1);
      out_r.root_vertex    <= VID_W'(recent_r);
      out_r.out_of_range   <= bad_r;
      out_r.last_out       <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  assign stat.clr_more     = clr_idx_r < limit_r;
  assign stat.bad          = bad_r;
  assign stat.hit          = q_par == cur_r;
  assign stat.end_is_root  = end_v == cur_r;
  assign stat.next_is_root = q_par == root_sel;
  assign stat.same_root    = root_a_r == root_b_r;
  assign stat.rank_eq      = rank_a_r == rank_b_r;

endmodule

@@ hw/rtl/kruskal_union_find_edge_filter.sv @@
// Kruskal edge filter: disjoint-set forest with union by rank and path
// compression over one parent/rank RAM. Pulse start while busy is low to hand
// in one edge; one result follows on out_data with a one-cycle out_valid
// strobe, which the receiver must take. An edge keeps the block busy through
// two find walks with compression and a link step, plus a rank update when
// two roots of equal rank are joined. Each walk follows the path from an
// endpoint to its root (at most log2 of the vertex count long); every step is
// one access of the single-read, single-write RAM, so the find and
// compression walks set the busy time. An out-of-range edge skips the walks.
// A start item first sweeps the min(num_vertices, MAX_VERTICES) vertices
// in use, one per cycle; after reset the block stays busy while it
// initializes every entry.
// num_vertices may be written through cfg_we/cfg_wdata while busy is low.
// Depends on kuf_pkg, kuf_ctrl, kuf_datapath, kuf_ram.
module kruskal_union_find_edge_filter
  import kuf_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  kuf_in_t          in_data,
  output logic             out_valid,
  output kuf_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  kuf_cmd_t  cmd;
  kuf_stat_t stat;

  kuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_req (in_data.start_req),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  kuf_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/kuf_checker.sv @@
// Port-level checks for the union-find edge filter, bound to the top level.
// Depends on kuf_pkg.
module kuf_checker
  import kuf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input kuf_out_t out_data
);

  // one result per item, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid high in two consecutive cycles");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was accepted");

  // a result appears as the block goes idle
  a_result_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the busy-to-idle transition");

  // a flagged edge never enters the tree
  a_bad_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |-> !out_data.accepted)
    else $error("out-of-range edge reported as accepted");

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
